/* design/tdcd_pkg.sv */
`default_nettype none

package tdcd_pkg;

	localparam int TIME_W = 63;
	localparam int NUM_W  = 42;
	localparam int DEN_W  = 16;
	localparam int QUO_W  = 36;

	localparam logic [2:0] KIND_HEADER = 3'd1;
	localparam logic [2:0] KIND_DEBUG  = 3'd2;
	localparam logic [2:0] KIND_EPOCH  = 3'd3;
	localparam logic [2:0] KIND_HIT    = 3'd4;
	localparam logic [2:0] KIND_HIT1   = 3'd5;
	localparam logic [2:0] KIND_CALIB  = 3'd7;

	localparam logic [1:0] REG_FINE_LOW  = 2'd0;
	localparam logic [1:0] REG_FINE_HIGH = 2'd1;
	localparam logic [1:0] REG_LIMIT_FS  = 2'd2;

	localparam logic [1:0] EP_NONE  = 2'd0;
	localparam logic [1:0] EP_NEW   = 2'd1;
	localparam logic [1:0] EP_OWNED = 2'd2;

	localparam logic [22:0] COARSE_FS   = 23'd5000000;
	localparam logic [9:0]  FINE_NONE   = 10'h3ff;
	localparam logic [13:0] CALIB_FULL  = 14'h3ffe;
	localparam logic [13:0] CALIB_RESET = 14'h3fff;
	localparam logic [12:0] CAL_FOLD    = 13'h1fff;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             busy;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

/* design/tdc_word_stream_decoder.sv */
// Each word passes ST_MUL, then ST_DIV if it takes a calibration correction
// (two mod-8191 folds and a final compare) or the linear ramp (the 42-step
// bit-serial divider), then ST_SUM and ST_FIN.
// One word in flight: no new word until ST_FIN passes; output stalls hold it.
// Reset (arst_n low) clears control, block state and valid bits at once;
// no clearing pass. Registers return to fine_low 31, fine_high 491, limit 0.
`default_nettype none

module tdc_word_stream_decoder #(
	parameter int NUM_CHANNELS = 128
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output      logic          s_tready,
	input  wire logic [31:0]   s_tdata,   // word
	input  wire logic          s_tuser,   // first
	input  wire logic          s_tlast,
	output      logic          m_tvalid,
	input  wire logic          m_tready,
	// word_kind[2:0] channel[9:3] rising[10] hit_time_fs[73:11] tot_valid[74]
	// tot_fs[137:75] tot_below_limit[138] error_bits[142:139] pad[143]
	output      logic [143:0]  m_tdata,
	output      logic          m_tlast,   // end_res
	input  wire logic          cfg_valid,
	output      logic          cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [39:0]   cfg_data
);

	localparam int AW = $clog2(NUM_CHANNELS);
	localparam int TW = tdcd_pkg::TIME_W;
	localparam int QW = tdcd_pkg::QUO_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_SUM  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_H1R,
		MODE_H1F,
		MODE_CAL,
		MODE_LIN
	} mode_t;

	state_t state_q;

	logic [9:0]  fine_low_q;
	logic [9:0]  fine_high_q;
	logic [39:0] limit_q;

	logic [27:0] epoch_val_q;
	logic [1:0]  epoch_stat_q;
	logic [6:0]  epoch_own_q;
	logic [13:0] cal0_q;
	logic [13:0] cal1_q;
	logic [1:0]  cal_used_q;
	logic        seen0_q;
	logic        seend_q;
	logic [1:0]  hcnt_q;
	logic [1:0]  wcnt_q;
	logic [3:0]  errf_q;
	logic [NUM_CHANNELS-1:0] rise_vld_q;

	logic [27:0] n_epoch_val;
	logic [1:0]  n_epoch_stat;
	logic [6:0]  n_epoch_own;
	logic [13:0] n_cal0;
	logic [13:0] n_cal1;
	logic [1:0]  n_cal_used;
	logic        n_seen0;
	logic        n_seend;
	logic [1:0]  n_hcnt;
	logic [1:0]  n_wcnt;
	logic [3:0]  n_errf;
	mode_t       n_mode;
	logic [13:0] n_cal_val;

	logic [2:0]  in_kind;
	logic [6:0]  in_ch;
	logic [9:0]  in_fine;
	logic        in_rise;
	logic        in_hit;
	logic        in_rng;
	logic [AW-1:0] in_idx;
	logic        acc;

	logic [2:0]  kind_q;
	logic [6:0]  ch_q;
	logic [AW-1:0] idx_q;
	logic        rise_q;
	logic        hit_q;
	logic        last_q;
	logic        rng_q;
	logic        prev_vld_q;
	logic [3:0]  err_out_q;
	logic [38:0] coarse_q;
	mode_t       mode_q;
	logic [9:0]  fine_q;
	logic [13:0] cal_val_q;
	logic [9:0]  lin_d_q;
	logic [9:0]  lin_den_q;

	logic [42:0] p_lo_q;
	logic [41:0] p_hi_q;
	logic [QW-1:0] corr_q;
	logic [63:0] t_q;

	// calibration divide by 2*8191: residue fold, quotient and step count
	logic [38:0]   cm_q;
	logic [QW-1:0] cq_q;
	logic [1:0]    cstep_q;
	logic          cal_done;

	logic [TW-1:0] rd_data;
	logic          mem_we;
	logic [63:0]   tot;
	logic          tot_v;
	logic          below;
	logic          out_free;

	logic [32:0] lin_prod;

	tdcd_pkg::div_req_t div_req;
	tdcd_pkg::div_rsp_t div_rsp;

	assign acc       = s_tvalid && s_tready;
	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;

	assign in_kind = s_tdata[31:29];
	assign in_ch   = s_tdata[28:22];
	assign in_fine = s_tdata[21:12];
	assign in_rise = s_tdata[11];
	assign in_hit  = in_kind == tdcd_pkg::KIND_HIT || in_kind == tdcd_pkg::KIND_HIT1;
	assign in_rng  = {1'b0, in_ch} < 8'(NUM_CHANNELS);
	assign in_idx  = in_ch[AW-1:0];

	always_comb begin
		n_epoch_val  = s_tuser ? '0 : epoch_val_q;
		n_epoch_stat = s_tuser ? tdcd_pkg::EP_NONE : epoch_stat_q;
		n_epoch_own  = s_tuser ? '0 : epoch_own_q;
		n_cal0       = s_tuser ? tdcd_pkg::CALIB_RESET : cal0_q;
		n_cal1       = s_tuser ? tdcd_pkg::CALIB_RESET : cal1_q;
		n_cal_used   = s_tuser ? 2'd2 : cal_used_q;
		n_seen0      = s_tuser ? 1'b0 : seen0_q;
		n_seend      = s_tuser ? 1'b0 : seend_q;
		n_hcnt       = s_tuser ? 2'd0 : hcnt_q;
		n_wcnt       = s_tuser ? 2'd0 : wcnt_q;
		n_errf       = s_tuser ? 4'd0 : errf_q;
		n_mode       = MODE_NONE;
		n_cal_val    = n_cal_used[0] ? n_cal1 : n_cal0;
		if (s_tuser && in_kind != tdcd_pkg::KIND_HEADER) begin
			n_errf[0] = 1'b1;
		end
		if (n_wcnt < 2'd2) begin
			n_wcnt = n_wcnt + 2'd1;
		end
		case (in_kind)
			tdcd_pkg::KIND_HEADER: begin
				if (n_hcnt < 2'd3) begin
					n_hcnt = n_hcnt + 2'd1;
				end
			end
			tdcd_pkg::KIND_DEBUG: begin
				n_seend = 1'b1;
			end
			tdcd_pkg::KIND_EPOCH: begin
				n_epoch_val  = s_tdata[27:0];
				n_epoch_stat = tdcd_pkg::EP_NEW;
			end
			tdcd_pkg::KIND_CALIB: begin
				n_cal0     = s_tdata[13:0];
				n_cal1     = s_tdata[27:14];
				n_cal_used = 2'd0;
			end
			tdcd_pkg::KIND_HIT, tdcd_pkg::KIND_HIT1: begin
				if (in_ch == 7'd0) begin
					n_seen0 = 1'b1;
				end
				if (n_epoch_stat == tdcd_pkg::EP_NEW) begin
					n_epoch_own  = in_ch;
					n_epoch_stat = tdcd_pkg::EP_OWNED;
				end
				if (n_epoch_stat == tdcd_pkg::EP_NONE || n_epoch_own != in_ch) begin
					n_errf[2] = 1'b1;
				end
				if (in_fine != tdcd_pkg::FINE_NONE) begin
					if (in_kind == tdcd_pkg::KIND_HIT1) begin
						n_mode = in_rise ? MODE_H1R : MODE_H1F;
					end else if (n_cal_used < 2'd2) begin
						n_mode     = MODE_CAL;
						n_cal_used = n_cal_used + 2'd1;
					end else if (in_fine > fine_low_q && fine_high_q > fine_low_q) begin
						n_mode = MODE_LIN;
					end
				end
			end
			default: begin
			end
		endcase
		if (s_tlast) begin
			if (n_wcnt < 2'd2) begin
				if (n_hcnt != 2'd1) begin
					n_errf[3] = 1'b1;
				end
			end else if (!n_seen0 && !n_seend) begin
				n_errf[1] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_low_q  <= 10'd31;
			fine_high_q <= 10'd491;
			limit_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tdcd_pkg::REG_FINE_LOW:  fine_low_q  <= cfg_data[9:0];
				tdcd_pkg::REG_FINE_HIGH: fine_high_q <= cfg_data[9:0];
				tdcd_pkg::REG_LIMIT_FS:  limit_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_val_q  <= '0;
			epoch_stat_q <= tdcd_pkg::EP_NONE;
			epoch_own_q  <= '0;
			cal0_q       <= tdcd_pkg::CALIB_RESET;
			cal1_q       <= tdcd_pkg::CALIB_RESET;
			cal_used_q   <= 2'd2;
			seen0_q      <= 1'b0;
			seend_q      <= 1'b0;
			hcnt_q       <= '0;
			wcnt_q       <= '0;
			errf_q       <= '0;
		end else if (acc) begin
			epoch_val_q  <= n_epoch_val;
			epoch_stat_q <= n_epoch_stat;
			epoch_own_q  <= n_epoch_own;
			cal0_q       <= n_cal0;
			cal1_q       <= n_cal1;
			cal_used_q   <= n_cal_used;
			seen0_q      <= n_seen0;
			seend_q      <= n_seend;
			hcnt_q       <= n_hcnt;
			wcnt_q       <= n_wcnt;
			errf_q       <= n_errf;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q     <= in_kind;
			ch_q       <= in_ch;
			idx_q      <= in_idx;
			rise_q     <= in_rise;
			hit_q      <= in_hit;
			last_q     <= s_tlast;
			rng_q      <= in_rng;
			prev_vld_q <= !s_tuser && in_rng && rise_vld_q[in_idx];
			err_out_q  <= s_tlast ? n_errf : 4'd0;
			coarse_q   <= {n_epoch_val, s_tdata[10:0]};
			mode_q     <= n_mode;
			fine_q     <= in_fine;
			cal_val_q  <= n_cal_val;
			lin_d_q    <= in_fine - fine_low_q;
			lin_den_q  <= fine_high_q - fine_low_q;
		end
	end

	assign cal_done = mode_q == MODE_CAL && cstep_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= (div_req.start || mode_q == MODE_CAL) ? ST_DIV : ST_SUM;
				end
				ST_DIV: begin
					if (div_rsp.done || cal_done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign lin_prod = 33'(lin_d_q) * 33'(tdcd_pkg::COARSE_FS);

	always_comb begin
		div_req.start = state_q == ST_MUL && mode_q == MODE_LIN;
		div_req.num   = 42'({lin_prod, 1'b0}) + 42'(lin_den_q);
		div_req.den   = 16'({lin_den_q, 1'b0});
	end

	tdcd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			p_lo_q  <= 43'(coarse_q[19:0]) * 43'(tdcd_pkg::COARSE_FS);
			p_hi_q  <= 42'(coarse_q[38:20]) * 42'(tdcd_pkg::COARSE_FS);
			// round(c*k/16382) = floor((c*k/2 + 4095) / 8191)
			cm_q    <= 39'(cal_val_q) * (rise_q ? 39'd2500000 : 39'd25000000) + 39'd4095;
			cq_q    <= '0;
			cstep_q <= '0;
			case (mode_q)
				MODE_H1R: corr_q <= 36'(fine_q) * 36'd5000;
				MODE_H1F: corr_q <= 36'(fine_q[8:0]) * 36'd10000
					+ (fine_q[9] ? 36'd10240000000 : 36'd0);
				default:  corr_q <= '0;
			endcase
		end else if (state_q == ST_DIV) begin
			if (mode_q == MODE_CAL) begin
				if (cstep_q != 2'd2) begin
					cq_q    <= cq_q + QW'(cm_q[38:13]);
					cm_q    <= 39'(cm_q[38:13]) + 39'(cm_q[12:0]);
					cstep_q <= cstep_q + 2'd1;
				end else begin
					corr_q <= cq_q
						+ ((cm_q >= 39'(tdcd_pkg::CALIB_FULL)) ? QW'(2)
						: (cm_q >= 39'(tdcd_pkg::CAL_FOLD)) ? QW'(1) : QW'(0));
				end
			end else if (div_rsp.done) begin
				corr_q <= div_rsp.quo;
			end
		end
		if (state_q == ST_SUM) begin
			t_q <= 64'({p_hi_q, 20'b0}) + 64'(p_lo_q) - 64'(corr_q);
		end
	end

	assign tot   = t_q - {rd_data[TW-1], rd_data};
	assign tot_v = hit_q && rng_q && !rise_q && prev_vld_q;
	assign below = tot_v && limit_q != '0 && $signed(tot) < $signed({24'b0, limit_q});
	assign mem_we = state_q == ST_FIN && out_free && hit_q && rng_q && rise_q;

	tdcd_rise_mem #(
		.DEPTH (NUM_CHANNELS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (idx_q),
		.wr_data (t_q[TW-1:0]),
		.rd_en   (acc),
		.rd_addr (in_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_vld_q <= '0;
		end else if (acc && s_tuser) begin
			rise_vld_q <= '0;
		end else if (state_q == ST_FIN && out_free && hit_q && rng_q) begin
			if (rise_q) begin
				rise_vld_q[idx_q] <= 1'b1;
			end else if (prev_vld_q) begin
				rise_vld_q[idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			m_tdata <= {1'b0,
				err_out_q,
				below,
				tot_v ? tot[TW-1:0] : {TW{1'b0}},
				tot_v,
				hit_q ? t_q[TW-1:0] : {TW{1'b0}},
				hit_q ? rise_q : 1'b0,
				hit_q ? ch_q : 7'd0,
				kind_q};
			m_tlast <= last_q;
		end
	end

	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tuser |=> rise_vld_q == '0)
		else $error("rise valid bits not cleared by first word");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_idle_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_rsp.busy)
		else $error("divider busy while idle");

endmodule

`default_nettype wire

/* design/tdcd_rise_mem.sv */
`default_nettype none

module tdcd_rise_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [tdcd_pkg::TIME_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	output      logic [tdcd_pkg::TIME_W-1:0] rd_data
);

	logic [tdcd_pkg::TIME_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* design/tdcd_divider.sv */
`default_nettype none

module tdcd_divider (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tdcd_pkg::div_req_t   req,
	output      tdcd_pkg::div_rsp_t   rsp
);

	localparam int NW = tdcd_pkg::NUM_W;
	localparam int DW = tdcd_pkg::DEN_W;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			num_q <= req.num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quo  = quo_q[tdcd_pkg::QUO_W-1:0];

endmodule

`default_nettype wire

/* dv/tb_tdc_word_stream_decoder.sv */
`timescale 1ns / 1ps

module tb_tdc_word_stream_decoder;

	localparam logic [2:0] KIND_TRAILER = 3'd0;
	localparam logic [2:0] KIND_SIX     = 3'd6;

	typedef struct {
		logic [2:0]  kind;
		logic [6:0]  chan;
		logic        rise;
		logic [62:0] hit_fs;
		logic        tot_ok;
		logic [62:0] tot;
		logic        below;
		logic [3:0]  err;
		logic        eow;
	} decoded_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic         m_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [39:0]  cfg_data;

	tdc_word_stream_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// decoder model state
	logic [9:0]  fine_lo, fine_hi;
	logic [39:0] limit_fs;
	logic [27:0] ep_val;
	logic [1:0]  ep_stat;
	logic [6:0]  ep_owner;
	logic [13:0] cal_val [2];
	int          cal_used;
	longint      rise_fs [128];
	bit          rise_ok [128];
	bit          seen_ch0, seen_dbg;
	int          hdr_cnt, word_cnt;
	logic [3:0]  err_flags;

	decoded_t    expected_words[$];
	int          errors;
	int          src_idle_pct, snk_stall_pct;
	int          stall_request;
	int          words_sent;

	function automatic void clear_block();
		ep_val = '0;
		ep_stat = tdcd_pkg::EP_NONE;
		ep_owner = '0;
		cal_val[0] = tdcd_pkg::CALIB_RESET;
		cal_val[1] = tdcd_pkg::CALIB_RESET;
		cal_used = 2;
		for (int i = 0; i < 128; i++) begin
			rise_fs[i] = 0;
			rise_ok[i] = 0;
		end
		seen_ch0 = 0;
		seen_dbg = 0;
		hdr_cnt = 0;
		word_cnt = 0;
		err_flags = '0;
	endfunction

	function automatic longint round_div(logic [63:0] num, logic [63:0] den);
		return longint'((2 * num + den) / (2 * den));
	endfunction

	function automatic longint corrected_fs(logic [31:0] w, logic [2:0] kind, logic rise);
		logic [63:0] coarse;
		longint      t;
		logic [9:0]  fine;
		logic [63:0] k;
		coarse = ({36'd0, ep_val} << 11) + {53'd0, w[10:0]};
		t = longint'(coarse) * 64'sd5000000;
		fine = w[21:12];
		if (fine == tdcd_pkg::FINE_NONE)
			return t;
		if (kind == tdcd_pkg::KIND_HIT1) begin
			if (rise) begin
				t -= longint'(fine) * 5000;
			end else begin
				t -= longint'(fine[8:0]) * 10000;
				if (fine[9])
					t -= 64'sd2048 * 64'sd5000000;
			end
		end else if (cal_used < 2) begin
			k = rise ? 64'd5000000 : 64'd50000000;
			t -= round_div({50'd0, cal_val[cal_used & 1]} * k, {50'd0, tdcd_pkg::CALIB_FULL});
			cal_used++;
		end else if (fine > fine_lo && fine_hi > fine_lo) begin
			t -= round_div({54'd0, fine - fine_lo} * 64'd5000000, {54'd0, fine_hi - fine_lo});
		end
		return t;
	endfunction

	function automatic decoded_t decode_word(logic [31:0] w, logic f, logic l);
		decoded_t   d;
		logic [6:0] ch;
		longint     t, tot;
		d = '{kind: w[31:29], chan: '0, rise: 0, hit_fs: '0, tot_ok: 0, tot: '0,
			below: 0, err: '0, eow: l};
		if (f) begin
			clear_block();
			if (d.kind != tdcd_pkg::KIND_HEADER)
				err_flags[0] = 1;
		end
		if (word_cnt < 2)
			word_cnt++;
		case (d.kind)
			tdcd_pkg::KIND_HEADER: if (hdr_cnt < 3) hdr_cnt++;
			tdcd_pkg::KIND_DEBUG: seen_dbg = 1;
			tdcd_pkg::KIND_EPOCH: begin
				ep_val = w[27:0];
				ep_stat = tdcd_pkg::EP_NEW;
			end
			tdcd_pkg::KIND_CALIB: begin
				cal_val[0] = w[13:0];
				cal_val[1] = w[27:14];
				cal_used = 0;
			end
			tdcd_pkg::KIND_HIT, tdcd_pkg::KIND_HIT1: begin
				ch = w[28:22];
				if (ch == 0)
					seen_ch0 = 1;
				if (ep_stat == tdcd_pkg::EP_NEW) begin
					ep_owner = ch;
					ep_stat = tdcd_pkg::EP_OWNED;
				end
				if (ep_stat == tdcd_pkg::EP_NONE || ep_owner != ch)
					err_flags[2] = 1;
				t = corrected_fs(w, d.kind, w[11]);
				d.chan = ch;
				d.rise = w[11];
				d.hit_fs = t[62:0];
				if (w[11]) begin
					rise_fs[ch] = t;
					rise_ok[ch] = 1;
				end else if (rise_ok[ch]) begin
					tot = t - rise_fs[ch];
					rise_ok[ch] = 0;
					d.tot_ok = 1;
					d.tot = tot[62:0];
					d.below = (limit_fs != 0) && (tot < longint'({24'd0, limit_fs}));
				end
			end
			default: ;
		endcase
		if (l) begin
			if (word_cnt < 2) begin
				if (hdr_cnt != 1)
					err_flags[3] = 1;
			end else if (!seen_ch0 && !seen_dbg) begin
				err_flags[1] = 1;
			end
			d.err = err_flags;
		end
		return d;
	endfunction

	task automatic send_word(logic [31:0] w, logic f, logic l);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= f;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_words = {expected_words, decode_word(w, f, l)};
		words_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			tdcd_pkg::REG_FINE_LOW: fine_lo = val[9:0];
			tdcd_pkg::REG_FINE_HIGH: fine_hi = val[9:0];
			tdcd_pkg::REG_LIMIT_FS: limit_fs = val;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] hit_word(logic [2:0] kind, logic [6:0] ch,
		logic [9:0] fine, logic rise, logic [10:0] coarse);
		return {kind, ch, fine, rise, coarse};
	endfunction

	function automatic logic [9:0] rand_fine();
		case ($urandom_range(9))
			0: return tdcd_pkg::FINE_NONE;
			1: return 10'd0;
			default: return 10'($urandom);
		endcase
	endfunction

	// one sub-subevent, mostly well formed
	task automatic send_block();
		logic [6:0] ch;
		logic [2:0] kind;
		int         nhits;
		ch = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom);
		nhits = $urandom_range(0, 8);
		send_word(($urandom_range(9) == 0) ? $urandom
			: {tdcd_pkg::KIND_HEADER, 29'($urandom)}, 1'b1, 1'b0);
		if ($urandom_range(6) != 0)
			send_word({tdcd_pkg::KIND_EPOCH, 1'($urandom),
				($urandom_range(7) == 0) ? 28'hfffffff : 28'($urandom)}, 1'b0, 1'b0);
		if ($urandom_range(4) == 0)
			send_word({tdcd_pkg::KIND_DEBUG, 29'($urandom)}, 1'b0, 1'b0);
		for (int i = 0; i < nhits; i++) begin
			if ($urandom_range(4) == 0)
				send_word({tdcd_pkg::KIND_CALIB, 29'($urandom)}, 1'b0, 1'b0);
			kind = $urandom_range(1) ? tdcd_pkg::KIND_HIT : tdcd_pkg::KIND_HIT1;
			if ($urandom_range(7) == 0)
				ch = 7'($urandom);
			send_word(hit_word(kind, ch, rand_fine(), 1'b1, 11'($urandom)), 1'b0, 1'b0);
			send_word(hit_word(kind, ch, rand_fine(), 1'($urandom_range(3) != 0),
				11'($urandom)), 1'b0, 1'b0);
		end
		case ($urandom_range(9))
			0: send_word($urandom, 1'b0, 1'b1);
			1: send_word($urandom, 1'($urandom), 1'b1);
			default: send_word({KIND_TRAILER, 29'($urandom)}, 1'b0, 1'b1);
		endcase
	endtask

	task automatic send_random(int nwords);
		int start;
		start = words_sent;
		while (words_sent - start < nwords) begin
			if ($urandom_range(7) == 0)
				send_word($urandom, 1'($urandom_range(3) == 0), 1'($urandom_range(3) == 0));
			else
				send_block();
		end
	endtask

	task automatic test_directed();
		send_word({tdcd_pkg::KIND_HEADER, 29'd0}, 1'b1, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd5, 10'd100, 1'b1, 11'd3), 1'b0, 1'b0);
		send_word({tdcd_pkg::KIND_EPOCH, 1'b0, 28'hfffffff}, 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd0, 10'd0, 1'b1, 11'h7ff), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd0, 10'h3fe, 1'b0, 11'h7ff), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT1, 7'd0, 10'h3fe, 1'b1, 11'd0), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT1, 7'd0, 10'h3fe, 1'b0, 11'd1), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT1, 7'd0, 10'h1ff, 1'b0, 11'd1), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd0, tdcd_pkg::FINE_NONE, 1'b1, 11'd9),
			1'b0, 1'b0);
		send_word({tdcd_pkg::KIND_CALIB, 1'b1, 14'h3fff, 14'd0}, 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd0, 10'd7, 1'b1, 11'd20), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd0, 10'd7, 1'b0, 11'd40), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd0, 10'd7, 1'b0, 11'd60), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd127, 10'd300, 1'b1, 11'd2), 1'b0, 1'b0);
		send_word(hit_word(tdcd_pkg::KIND_HIT, 7'd127, 10'd300, 1'b0, 11'd1), 1'b0, 1'b0);
		send_word({tdcd_pkg::KIND_DEBUG, 29'h1fffffff}, 1'b0, 1'b0);
		send_word({KIND_SIX, 29'h1fffffff}, 1'b0, 1'b0);
		send_word({KIND_TRAILER, 29'h1fffffff}, 1'b0, 1'b1);
		send_word(32'hffffffff, 1'b0, 1'b0);
		send_word({tdcd_pkg::KIND_HEADER, 29'd0}, 1'b1, 1'b1);
		send_word({tdcd_pkg::KIND_EPOCH, 29'd1}, 1'b1, 1'b1);
		send_word({tdcd_pkg::KIND_HEADER, 29'd0}, 1'b1, 1'b0);
		send_word({tdcd_pkg::KIND_HEADER, 29'd0}, 1'b0, 1'b0);
		send_word({KIND_TRAILER, 29'd0}, 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_config_settings();
		write_reg(tdcd_pkg::REG_FINE_LOW, 40'd0);
		write_reg(tdcd_pkg::REG_FINE_HIGH, 40'd1023);
		write_reg(tdcd_pkg::REG_LIMIT_FS, 40'hffffffffff);
		send_random(120);
		drain();
		write_reg(tdcd_pkg::REG_FINE_LOW, 40'd1023);
		write_reg(tdcd_pkg::REG_FINE_HIGH, 40'd0);
		write_reg(tdcd_pkg::REG_LIMIT_FS, 40'd0);
		send_random(60);
		drain();
		write_reg(tdcd_pkg::REG_FINE_LOW, 40'd500);
		write_reg(tdcd_pkg::REG_FINE_HIGH, 40'd500);
		write_reg(tdcd_pkg::REG_LIMIT_FS, 40'($urandom_range(20000)) * 40'd1000000);
		send_random(60);
		drain();
		write_reg(tdcd_pkg::REG_FINE_LOW, 40'($urandom_range(200)));
		write_reg(tdcd_pkg::REG_FINE_HIGH, 40'($urandom_range(300, 1023)));
		write_reg(tdcd_pkg::REG_LIMIT_FS, 40'($urandom_range(20000)) * 40'd1000000);
	endtask

	task automatic test_idle_phases();
		src_idle_pct = 67;
		send_random(120);
		src_idle_pct = 0;
		snk_stall_pct = 67;
		send_random(120);
		src_idle_pct = 38;
		snk_stall_pct = 38;
		send_random(120);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_random(60);
		drain();
	endtask

	task automatic test_backpressure();
		stall_request = 400;
		send_random(100);
		drain();
	endtask

	always @(posedge clk) begin
		decoded_t exp_w;
		if (m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				errors++;
			end else begin
				exp_w = expected_words.pop_front();
				if (m_tdata[2:0] != exp_w.kind) begin
					$error("word_kind exp %0d got %0d", exp_w.kind, m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[9:3] != exp_w.chan) begin
					$error("channel exp %0d got %0d", exp_w.chan, m_tdata[9:3]);
					errors++;
				end
				if (m_tdata[10] != exp_w.rise) begin
					$error("rising exp %0d got %0d", exp_w.rise, m_tdata[10]);
					errors++;
				end
				if (m_tdata[73:11] != exp_w.hit_fs) begin
					$error("hit_time_fs exp %h got %h", exp_w.hit_fs, m_tdata[73:11]);
					errors++;
				end
				if (m_tdata[74] != exp_w.tot_ok) begin
					$error("tot_valid exp %0d got %0d", exp_w.tot_ok, m_tdata[74]);
					errors++;
				end
				if (m_tdata[137:75] != exp_w.tot) begin
					$error("tot_fs exp %h got %h", exp_w.tot, m_tdata[137:75]);
					errors++;
				end
				if (m_tdata[138] != exp_w.below) begin
					$error("tot_below_limit exp %0d got %0d", exp_w.below, m_tdata[138]);
					errors++;
				end
				if (m_tdata[142:139] != exp_w.err) begin
					$error("error_bits exp %h got %h", exp_w.err, m_tdata[142:139]);
					errors++;
				end
				if (m_tlast != exp_w.eow) begin
					$error("end_res exp %0d got %0d", exp_w.eow, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int hold;
		if (stall_request > 0) begin
			hold = stall_request;
			stall_request = 0;
		end
		if (hold > 0) begin
			hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		errors = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		stall_request = 0;
		words_sent = 0;
		fine_lo = 10'd31;
		fine_hi = 10'd491;
		limit_fs = '0;
		clear_block();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= tdcd_pkg::REG_FINE_LOW;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_settings();
		test_idle_phases();
		test_backpressure();
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
